// ----- rtl/kga_pkg.sv -----
// Shared constants, types and arithmetic helpers for the keyed group average block.
`default_nettype none
package kga_pkg;

  // Number of accumulated fields, and the number of field lanes on the ports.
  localparam int FIELDS = 4;
  localparam int MAXF   = 4;
  localparam int FIDX_W = (FIELDS > 1) ? $clog2(FIELDS) : 1;

  // Divider runs one quotient bit per cycle over the 64-bit dividend.
  localparam int DIV_STEPS  = 64;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic CFG_STRICT_NULL = 1'b0;
  localparam logic CFG_USE_KEY     = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              take;       // input beat accepted this cycle
    logic              div_start;  // load the divider with field fidx
    logic              div_store;  // store the divider result for field fidx
    logic [FIDX_W-1:0] fidx;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic brk;       // the presented beat closes the open group
    logic div_done;  // divider result is ready
  } dp_stat_t;

  // Signed 64-bit sum plus a signed 32-bit value, saturating at the 64-bit bounds.
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] s,
                                                 input logic signed [31:0] v);
    logic signed [64:0] sum;
    begin
      sum = {s[63], s} + {{33{v[31]}}, v};
      if (sum[64] != sum[63]) begin
        sat_add = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        sat_add = sum[63:0];
      end
    end
  endfunction

  // Count increment that holds at all ones.
  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    begin
      sat_inc = (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    end
  endfunction

endpackage
`default_nettype wire

// ----- rtl/kga_div.sv -----
// Iterative signed 64-bit by unsigned 32-bit divider, one quotient bit per cycle.
`default_nettype none
module kga_div
  import kga_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [31:0]        divisor,
  output logic                    done,
  output logic signed [31:0]      quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] step_r, step_nxt;
  logic                 neg_r, neg_nxt;
  logic [31:0]          dsr_r, dsr_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [63:0]          quo_r, quo_nxt;
  logic [32:0]          trial;
  logic [63:0]          mag;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    mag      = dividend[63] ? 64'd0 - dividend : dividend;
    trial    = {rem_r, quo_r[63]} - {1'b0, dsr_r};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = dividend[63];
      dsr_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = mag;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[63]};
      end
      quo_nxt  = {quo_r[62:0], ~trial[32]};
      step_nxt = step_r + 1'b1;
      if (step_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flags are reset; the operand registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    dsr_r  <= dsr_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  // Apply the sign and clamp to the 32-bit signed range.
  always_comb begin
    if (neg_r) begin
      if (quo_r > 64'h0000_0000_8000_0000) begin
        quotient = 32'sh8000_0000;
      end else begin
        quotient = 32'd0 - quo_r[31:0];
      end
    end else begin
      if (quo_r > 64'h0000_0000_7FFF_FFFF) begin
        quotient = 32'sh7FFF_FFFF;
      end else begin
        quotient = quo_r[31:0];
      end
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ----- rtl/kga_datapath.sv -----
// Accumulators, group snapshot, shared divider and result registers.
`default_nettype none
module kga_datapath
  import kga_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic               cfg_wdata,
  input  wire logic [31:0]        in_group_key,
  input  wire logic               in_end_of_input,
  input  wire logic signed [31:0] in_value [FIELDS],
  input  wire logic               in_present [FIELDS],
  input  wire ctrl_cmd_t          cmd,
  output dp_stat_t                stat,
  output logic [31:0]             res_key,
  output logic signed [31:0]      res_avg [FIELDS],
  output logic                    res_null [FIELDS]
);

  logic               strict_r;
  logic               use_key_r;
  logic               open_r;
  logic [31:0]        key_r;
  logic signed [63:0] sum_r [FIELDS];
  logic [31:0]        cnt_r [FIELDS];
  logic [31:0]        rec_r;
  logic [31:0]        snap_key_r;
  logic signed [63:0] snap_sum_r [FIELDS];
  logic [31:0]        snap_cnt_r [FIELDS];
  logic               snap_null_r [FIELDS];
  logic signed [31:0] avg_r [FIELDS];
  logic               null_r [FIELDS];
  logic               fresh;
  logic               div_done;
  logic signed [31:0] div_q;

  // A beat closes the group on end of input, or on a key change when keys are used.
  always_comb begin
    if (in_end_of_input) begin
      stat.brk = open_r;
    end else begin
      stat.brk = open_r && use_key_r && (in_group_key != key_r);
    end
    stat.div_done = div_done;
  end

  // A record starts from empty sums when no group is open or the old one closes.
  assign fresh = stat.brk || !open_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r  <= 1'b0;
      use_key_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STRICT_NULL: strict_r  <= cfg_wdata;
        CFG_USE_KEY:     use_key_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Group open flag and key.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else if (cmd.take) begin
      open_r <= !in_end_of_input;
    end
    if (cmd.take && !in_end_of_input) begin
      key_r <= in_group_key;
    end
  end

  // Running sums and counts; they only matter while a group is open.
  always_ff @(posedge clk) begin
    if (cmd.take && !in_end_of_input) begin
      rec_r <= fresh ? 32'd1 : sat_inc(rec_r);
      for (int f = 0; f < FIELDS; f++) begin
        if (in_present[f]) begin
          sum_r[f] <= sat_add(fresh ? 64'sd0 : sum_r[f], in_value[f]);
          cnt_r[f] <= fresh ? 32'd1 : sat_inc(cnt_r[f]);
        end else if (fresh) begin
          sum_r[f] <= '0;
          cnt_r[f] <= '0;
        end
      end
    end
  end

  // Snapshot of the closing group for the divider.
  always_ff @(posedge clk) begin
    if (cmd.take && stat.brk) begin
      snap_key_r <= use_key_r ? key_r : 32'd0;
      for (int f = 0; f < FIELDS; f++) begin
        snap_sum_r[f]  <= sum_r[f];
        snap_cnt_r[f]  <= cnt_r[f];
        snap_null_r[f] <= (cnt_r[f] == 32'd0) || (strict_r && (cnt_r[f] != rec_r));
      end
    end
  end

  kga_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (snap_sum_r[cmd.fidx]),
    .divisor  (snap_cnt_r[cmd.fidx]),
    .done     (div_done),
    .quotient (div_q)
  );

  // Result registers, one field per divider pass.
  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      null_r[cmd.fidx] <= snap_null_r[cmd.fidx];
      avg_r[cmd.fidx]  <= snap_null_r[cmd.fidx] ? 32'sd0 : div_q;
    end
  end

  assign res_key  = snap_key_r;
  assign res_avg  = avg_r;
  assign res_null = null_r;

endmodule
`default_nettype wire

// ----- rtl/kga_ctrl.sv -----
// Controller state machine: input handshake, divider sequencing and result beat.
`default_nettype none
module kga_ctrl
  import kga_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_RUN   = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [FIDX_W-1:0] fidx_r, fidx_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    fidx_nxt      = fidx_r;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    cmd.take      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_store = 1'b0;
    cmd.fidx      = fidx_r;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.brk) begin
            fidx_nxt  = '0;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_RUN;
      end
      S_RUN: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          if (fidx_r == FIDX_W'(FIELDS - 1)) begin
            state_nxt = S_OUT;
          end else begin
            fidx_nxt  = fidx_r + 1'b1;
            state_nxt = S_START;
          end
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        // A beat that keeps the open group leaves the result alone, so it may flow in.
        in_stall = stat.brk;
        if (in_valid && !stat.brk) begin
          cmd.take = 1'b1;
        end
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fidx_r  <= fidx_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/keyed_group_average.sv -----
// Top level: per-key running averages over a key-sorted record stream.
// Unless the divider runs, a record that stays in the open group is taken at once, one per cycle.
// A beat that closes a group starts four passes of the shared bit-serial divider, one per field;
// the result beat is valid once the last pass is stored, and input stalls meanwhile.
// While the result waits, beats that keep the open group still flow; a closing beat stalls.
// Reset (rst_n low, synchronous) closes any open group, sets strict_null to 0 and use_key to 1.
`default_nettype none
module keyed_group_average
  import kga_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        in_group_key,
  input  wire logic               in_end_of_input,
  input  wire logic signed [31:0] in_value_a,
  input  wire logic               in_present_a,
  input  wire logic signed [31:0] in_value_b,
  input  wire logic               in_present_b,
  input  wire logic signed [31:0] in_value_c,
  input  wire logic               in_present_c,
  input  wire logic signed [31:0] in_value_d,
  input  wire logic               in_present_d,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [31:0]             out_key,
  output logic signed [31:0]      out_avg_a,
  output logic                    out_null_a,
  output logic signed [31:0]      out_avg_b,
  output logic                    out_null_b,
  output logic signed [31:0]      out_avg_c,
  output logic                    out_null_c,
  output logic signed [31:0]      out_avg_d,
  output logic                    out_null_d
);

  ctrl_cmd_t          cmd;
  dp_stat_t           stat;
  logic signed [31:0] val_all [MAXF];
  logic               pres_all [MAXF];
  logic signed [31:0] val [FIELDS];
  logic               pres [FIELDS];
  logic signed [31:0] avg [FIELDS];
  logic               nul [FIELDS];
  logic signed [31:0] avg_all [MAXF];
  logic               nul_all [MAXF];

  // Gather the field lanes.
  assign val_all[0]  = in_value_a;
  assign val_all[1]  = in_value_b;
  assign val_all[2]  = in_value_c;
  assign val_all[3]  = in_value_d;
  assign pres_all[0] = in_present_a;
  assign pres_all[1] = in_present_b;
  assign pres_all[2] = in_present_c;
  assign pres_all[3] = in_present_d;

  // Used lanes come from the datapath; lanes beyond the field count read as null.
  for (genvar f = 0; f < MAXF; f++) begin : g_lane
    if (f < FIELDS) begin : g_used
      assign val[f]     = val_all[f];
      assign pres[f]    = pres_all[f];
      assign avg_all[f] = avg[f];
      assign nul_all[f] = nul[f];
    end else begin : g_unused
      assign avg_all[f] = 32'sd0;
      assign nul_all[f] = 1'b1;
    end
  end

  kga_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  kga_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_group_key    (in_group_key),
    .in_end_of_input (in_end_of_input),
    .in_value        (val),
    .in_present      (pres),
    .cmd             (cmd),
    .stat            (stat),
    .res_key         (out_key),
    .res_avg         (avg),
    .res_null        (nul)
  );

  // Spread the result lanes onto the ports.
  assign out_avg_a  = avg_all[0];
  assign out_null_a = nul_all[0];
  assign out_avg_b  = avg_all[1];
  assign out_null_b = nul_all[1];
  assign out_avg_c  = avg_all[2];
  assign out_null_c = nul_all[2];
  assign out_avg_d  = avg_all[3];
  assign out_null_d = nul_all[3];

endmodule
`default_nettype wire

// ----- bench/keyed_group_average_tb.sv -----
// Self-checking testbench for keyed_group_average: directed, back-pressure and random beats.
`timescale 1ns / 1ps
module keyed_group_average_tb;
  import kga_pkg::*;

  // Quiet cycles allowed before the run is abandoned, and the settle time after the last result.
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_CYCLES    = 800;
  localparam int RANDOM_CHUNK   = 280;

  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = longint'(64'h8000_0000_0000_0000);
  localparam longint AVG_MAX = 64'sd2147483647;
  localparam longint AVG_MIN = -64'sd2147483648;
  localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;

  // One input beat; lane 0 is field a.
  typedef struct packed {
    logic [31:0]       key;
    logic              eoi;
    logic [3:0][31:0]  val;
    logic [3:0]        pres;
  } rec_beat_t;

  // One closed group as the block reports it.
  typedef struct packed {
    logic [31:0]       key;
    logic [3:0][31:0]  avg;
    logic [3:0]        nul;
  } grp_avg_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_index;
  logic               cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [31:0]        in_group_key;
  logic               in_end_of_input;
  logic signed [31:0] in_value_a;
  logic               in_present_a;
  logic signed [31:0] in_value_b;
  logic               in_present_b;
  logic signed [31:0] in_value_c;
  logic               in_present_c;
  logic signed [31:0] in_value_d;
  logic               in_present_d;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        out_key;
  logic signed [31:0] out_avg_a;
  logic               out_null_a;
  logic signed [31:0] out_avg_b;
  logic               out_null_b;
  logic signed [31:0] out_avg_c;
  logic               out_null_c;
  logic signed [31:0] out_avg_d;
  logic               out_null_d;

  keyed_group_average dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_group_key    (in_group_key),
    .in_end_of_input (in_end_of_input),
    .in_value_a      (in_value_a),
    .in_present_a    (in_present_a),
    .in_value_b      (in_value_b),
    .in_present_b    (in_present_b),
    .in_value_c      (in_value_c),
    .in_present_c    (in_present_c),
    .in_value_d      (in_value_d),
    .in_present_d    (in_present_d),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_key         (out_key),
    .out_avg_a       (out_avg_a),
    .out_null_a      (out_null_a),
    .out_avg_b       (out_avg_b),
    .out_null_b      (out_null_b),
    .out_avg_c       (out_avg_c),
    .out_null_c      (out_null_c),
    .out_avg_d       (out_avg_d),
    .out_null_d      (out_null_d)
  );

  // Pacing knobs, set by the test sequence and read by the drivers.
  int send_gap_pct;
  int recv_stall_pct;
  int hold_requests;
  int errors;

  // Averages of groups already closed, oldest first.
  grp_avg_t expected_avgs[$];
  grp_avg_t next_avg;

  // Shadow copy of the aggregation state and mode registers.
  logic        mode_strict;
  logic        mode_use_key;
  logic [31:0] cur_key;
  logic        cur_open;
  longint      sum_acc [MAXF];
  logic [31:0] present_cnt [MAXF];
  logic [31:0] record_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor: empty the accumulators for a new group.
  function automatic void clear_sums();
    for (int f = 0; f < MAXF; f++) begin
      sum_acc[f] = 0;
      present_cnt[f] = '0;
    end
    record_cnt = '0;
  endfunction

  // Predictor: averages of the open group, with nulls and range clamping.
  function automatic grp_avg_t close_group();
    grp_avg_t r;
    longint q;
    r.key = mode_use_key ? cur_key : 32'd0;
    for (int f = 0; f < MAXF; f++) begin
      r.avg[f] = '0;
      r.nul[f] = 1'b1;
      if (f < FIELDS && present_cnt[f] != 0 &&
          !(mode_strict && present_cnt[f] != record_cnt)) begin
        q = sum_acc[f] / longint'({32'd0, present_cnt[f]});
        if (q > AVG_MAX) q = AVG_MAX;
        if (q < AVG_MIN) q = AVG_MIN;
        r.avg[f] = q[31:0];
        r.nul[f] = 1'b0;
      end
    end
    return r;
  endfunction

  // Predictor: fold one accepted beat in; returns 1 when it closes a group.
  function automatic bit fold_record(input rec_beat_t b, output grp_avg_t r);
    bit closes;
    longint v;
    closes = 1'b0;
    r = '0;
    if (b.eoi) begin
      if (cur_open) begin
        r = close_group();
        closes = 1'b1;
      end
      clear_sums();
      cur_open = 1'b0;
      return closes;
    end
    if (cur_open && mode_use_key && b.key != cur_key) begin
      r = close_group();
      closes = 1'b1;
      clear_sums();
    end
    for (int f = 0; f < FIELDS && f < MAXF; f++) begin
      if (b.pres[f]) begin
        v = longint'($signed(b.val[f]));
        if (v > 0 && sum_acc[f] > SUM_MAX - v) sum_acc[f] = SUM_MAX;
        else if (v < 0 && sum_acc[f] < SUM_MIN - v) sum_acc[f] = SUM_MIN;
        else sum_acc[f] = sum_acc[f] + v;
        if (present_cnt[f] != CNT_SAT) present_cnt[f] = present_cnt[f] + 32'd1;
      end
    end
    if (record_cnt != CNT_SAT) record_cnt = record_cnt + 32'd1;
    cur_key = b.key;
    cur_open = 1'b1;
    return closes;
  endfunction

  // Q16.16 value with the range ends and small numbers weighted up.
  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic rec_beat_t make_rec(input logic [31:0] key, input logic [3:0] pres,
                                         input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
    rec_beat_t r;
    r.key = key;
    r.eoi = 1'b0;
    r.val = {d, c, b, a};
    r.pres = pres;
    return r;
  endfunction

  // End-of-input beat; every other field is noise.
  function automatic rec_beat_t make_eoi();
    rec_beat_t r;
    r = make_rec($urandom, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
    r.eoi = 1'b1;
    return r;
  endfunction

  // Offer one beat, hold it until accepted, then update the prediction.
  task automatic send_beat(input rec_beat_t b);
    grp_avg_t r;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_group_key    <= b.key;
    in_end_of_input <= b.eoi;
    in_value_a      <= b.val[0];
    in_present_a    <= b.pres[0];
    in_value_b      <= b.val[1];
    in_present_b    <= b.pres[1];
    in_value_c      <= b.val[2];
    in_present_c    <= b.pres[2];
    in_value_d      <= b.val[3];
    in_present_d    <= b.pres[3];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fold_record(b, r)) expected_avgs.push_back(r);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Register write once all results are out and the divider has settled.
  task automatic write_reg(input logic idx, input logic val);
    stop_input();
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STRICT_NULL) mode_strict = val;
    else mode_use_key = val;
  endtask

  // Range ends, truncation toward zero, all-null groups and flushes with no group.
  task automatic test_extremes();
    send_beat(make_eoi());
    send_beat(make_rec(32'h0000_0000, 4'b1111, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h0000_0000, 32'hFFFF_FFFF));
    send_beat(make_rec(32'h0000_0000, 4'b0111, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h0000_0003, 32'h7FFF_FFFF));
    send_beat(make_rec(32'hFFFF_FFFF, 4'b0011, 32'hFFFF_FFFD, 32'h0000_0005,
                       32'h0, 32'h0));
    send_beat(make_rec(32'hFFFF_FFFF, 4'b0011, 32'h0000_0000, 32'hFFFF_FFFC,
                       32'h0, 32'h0));
    send_beat(make_eoi());
    send_beat(make_eoi());
    send_beat(make_rec(32'h0000_0001, 4'b0000, $urandom, $urandom, $urandom, $urandom));
    send_beat(make_rec(32'h0000_0002, 4'b0000, $urandom, $urandom, $urandom, $urandom));
    send_beat(make_eoi());
  endtask

  // Strict mode: a field missing from any record nulls its average.
  task automatic test_strict_null();
    write_reg(CFG_STRICT_NULL, 1'b1);
    send_beat(make_rec(32'h0000_0005, 4'b1101, 32'h0001_0000, 32'h0002_0000,
                       32'h0003_0000, 32'h0004_0000));
    send_beat(make_rec(32'h0000_0005, 4'b1011, 32'h0001_8000, 32'h0002_0000,
                       32'h0003_0000, 32'hFFFC_0000));
    send_beat(make_rec(32'h0000_0005, 4'b1111, 32'hFFFF_0000, 32'h0002_0000,
                       32'h0003_0000, 32'h0000_0001));
    send_beat(make_eoi());
    write_reg(CFG_STRICT_NULL, 1'b0);
  endtask

  // Key ignored: one group across key changes, reported with key zero.
  task automatic test_key_ignored();
    send_beat(make_rec(32'h0000_000A, 4'b1111, rand_q16(), rand_q16(), rand_q16(), rand_q16()));
    write_reg(CFG_USE_KEY, 1'b0);
    send_beat(make_rec(32'h0000_000B, 4'b1010, rand_q16(), rand_q16(), rand_q16(), rand_q16()));
    send_beat(make_rec(32'hFFFF_FFFF, 4'b0101, rand_q16(), rand_q16(), rand_q16(), rand_q16()));
    send_beat(make_eoi());
    send_beat(make_rec(32'h0000_0014, 4'b1111, rand_q16(), rand_q16(), rand_q16(), rand_q16()));
    write_reg(CFG_USE_KEY, 1'b1);
    send_beat(make_rec(32'h0000_0015, 4'b1111, rand_q16(), rand_q16(), rand_q16(), rand_q16()));
    send_beat(make_eoi());
  endtask

  // Receiver holds off for a long stretch while short groups keep arriving.
  task automatic test_output_backpressure();
    logic [31:0] key;
    int saved_gap;
    saved_gap = send_gap_pct;
    send_gap_pct = 0;
    hold_requests++;
    key = 32'h0000_1000;
    for (int g = 0; g < 4; g++) begin
      for (int k = 0; k < 3; k++) begin
        send_beat(make_rec(key, 4'($urandom), rand_q16(), rand_q16(), rand_q16(), rand_q16()));
      end
      key = key + 32'd1;
    end
    send_beat(make_eoi());
    send_gap_pct = saved_gap;
  endtask

  // Random groups of mostly short runs, with flushes mixed in.
  task automatic run_random(input int n_items, input int eoi_pct);
    logic [31:0] key;
    int group_left;
    key = $urandom;
    group_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < eoi_pct) begin
        send_beat(make_eoi());
      end else begin
        if (group_left == 0) begin
          case ($urandom_range(0, 3))
            0: key = key + 32'd1;
            1: key = key ^ (32'd1 << $urandom_range(0, 31));
            default: key = $urandom;
          endcase
          group_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        group_left--;
        send_beat(make_rec(key,
                           {$urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                            $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0},
                           rand_q16(), rand_q16(), rand_q16(), rand_q16()));
      end
    end
  endtask

  // Three pacing phases of two runs each; the register settings are rewritten before every run.
  task automatic test_random_traffic();
    int phase;
    for (int i = 0; i < 6; i++) begin
      phase = i / 2;
      write_reg(CFG_STRICT_NULL, (i % 3) != 0);
      write_reg(CFG_USE_KEY, phase != 1);
      send_gap_pct   = (phase == 0) ? 7 : (phase == 1) ? 75 : 0;
      recv_stall_pct = (phase == 0) ? 75 : (phase == 1) ? 7 : 0;
      run_random(RANDOM_CHUNK, (phase == 1) ? 10 : 4);
    end
  endtask

  // Receiver stall: random, or held high for a requested stretch.
  initial begin : recv_stall_gen
    int holds_done;
    int hold_left;
    holds_done = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  // Compare every accepted result beat with the oldest closed group.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_avgs.size() == 0) begin
        $error("result beat with no group closed: key %h", out_key);
        errors++;
      end else begin
        next_avg = expected_avgs.pop_front();
        check_field("out_key", next_avg.key, out_key);
        check_field("out_avg_a", next_avg.avg[0], out_avg_a);
        check_field("out_null_a", 32'(next_avg.nul[0]), 32'(out_null_a));
        check_field("out_avg_b", next_avg.avg[1], out_avg_b);
        check_field("out_null_b", 32'(next_avg.nul[1]), 32'(out_null_b));
        check_field("out_avg_c", next_avg.avg[2], out_avg_c);
        check_field("out_null_c", 32'(next_avg.nul[2]), 32'(out_null_c));
        check_field("out_avg_d", next_avg.avg[3], out_avg_d);
        check_field("out_null_d", 32'(next_avg.nul[3]), 32'(out_null_d));
      end
    end
  end

  // Watchdog: abandon the run after too many cycles with no beat on either side.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_avgs.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = 1'b0;
    cfg_wdata       = 1'b0;
    in_valid        = 1'b0;
    in_group_key    = '0;
    in_end_of_input = 1'b0;
    in_value_a      = '0;
    in_present_a    = 1'b0;
    in_value_b      = '0;
    in_present_b    = 1'b0;
    in_value_c      = '0;
    in_present_c    = 1'b0;
    in_value_d      = '0;
    in_present_d    = 1'b0;
    errors          = 0;
    hold_requests   = 0;
    send_gap_pct    = 7;
    recv_stall_pct  = 75;
    mode_strict     = 1'b0;
    mode_use_key    = 1'b1;
    cur_key         = '0;
    cur_open        = 1'b0;
    clear_sums();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_strict_null();
    test_key_ignored();
    test_output_backpressure();
    test_random_traffic();

    stop_input();
    while (expected_avgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
